// File: src/knn_majority_vote_classifier_unit_defines.svh
// Assertion macros for the k-nearest-neighbour classifier checker
`ifndef KNN_MAJORITY_VOTE_CLASSIFIER_UNIT_DEFINES_SVH
`define KNN_MAJORITY_VOTE_CLASSIFIER_UNIT_DEFINES_SVH

// hold cons in the same cycle as ante
`define KNN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// hold cons in the cycle after ante
`define KNN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/knn_pkg.sv
// Shared types, constants, command and status structs of the k-nearest-neighbour classifier
`default_nettype none
package knn_pkg;

  localparam int MaxSamples = 256;
  localparam int MaxDim     = 16;
  localparam int MaxK       = 16;
  localparam int NumClasses = 16;
  localparam int FeatBits   = 16;

  localparam int SampleW   = $clog2(MaxSamples);
  localparam int CountW    = SampleW + 1;
  localparam int DimW      = $clog2(MaxDim);
  localparam int LenW      = DimW + 1;
  localparam int KIdxW     = $clog2(MaxK);
  localparam int KW        = KIdxW + 1;
  localparam int ClassW    = $clog2(NumClasses);
  localparam int DistW     = 36;
  localparam int CfgW      = 5;
  localparam int FeatAddrW = SampleW + DimW;
  localparam int LabW      = LenW + ClassW;
  localparam int InDataW   = 24;
  localparam int OutDataW  = 40;

  localparam logic [DistW-1:0] DistCap = '1;

  typedef enum logic [1:0] {
    OP_TRAIN = 2'd0,
    OP_CLEAR = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FEW  = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    CFG_NEIGHBOR_COUNT = 1'b0,
    CFG_VECTOR_LENGTH  = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_TALLY,
    S_SCAN,
    S_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic                 feat_we;
    logic [FeatAddrW-1:0] feat_waddr;
    logic                 lab_we;
    logic [SampleW-1:0]   lab_waddr;
    logic [LenW-1:0]      lab_len;
    logic [ClassW-1:0]    lab_class;
    logic                 q_we;
    logic [DimW-1:0]      q_idx;
    logic                 qlen_we;
    logic [LenW-1:0]      qlen;
    logic                 rd_en;
    logic [SampleW-1:0]   rd_sample;
    logic [DimW-1:0]      rd_elem;
    logic                 rd_first;
    logic                 rd_last;
    logic                 best_clr;
    logic [KW-1:0]        kk;
    logic                 tally_clr;
    logic                 tally_en;
    logic [KIdxW-1:0]     tally_idx;
    logic                 scan_en;
    logic [ClassW-1:0]    scan_idx;
    logic                 out_load;
    logic                 out_normal;
    status_e              out_status;
  } dp_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// File: src/knn_ram.sv
// Generic simple dual-port RAM with registered read
`default_nettype none
module knn_ram #(
  parameter int Width = 16,
  parameter int Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: src/knn_datapath.sv
// Storage, distance pipeline, top-k list, vote tally and output register
`default_nettype none
module knn_datapath (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [knn_pkg::FeatBits-1:0]   feature_i,
  input  wire knn_pkg::dp_cmd_t               cmd_i,
  output knn_pkg::dp_stat_t                   stat_o,
  input  wire logic                           out_ready_i,
  output logic                                out_valid_o,
  output logic [knn_pkg::ClassW-1:0]          out_label_o,
  output knn_pkg::status_e                    out_status_o,
  output logic [knn_pkg::DistW-1:0]           out_dist_o
);
  import knn_pkg::*;

  logic [FeatBits-1:0] feat_rdata;
  logic [LabW-1:0]     lab_rdata;
  logic [LenW-1:0]     lab_len_rd;
  logic [ClassW-1:0]   lab_cls_rd;

  logic [FeatBits-1:0] q_q [MaxDim];
  logic [LenW-1:0]     qlen_q;

  logic                p1_v_q, p1_first_q, p1_last_q;
  logic [DimW-1:0]     p1_i_q;
  logic [FeatBits-1:0] tf, qf;
  logic [FeatBits:0]   diff, absd;

  logic                p2_v_q, p2_first_q, p2_last_q;
  logic [FeatBits:0]   p2_abs_q;
  logic [ClassW-1:0]   p2_cls_q;

  logic                     p3_v_q, p3_first_q, p3_last_q;
  logic [2*FeatBits+1:0]    p3_sq_q;
  logic [ClassW-1:0]        p3_cls_q;

  logic [DistW-1:0]  acc_q, acc_base, acc_sat;
  logic [DistW:0]    acc_sum;
  logic              d_v_q;
  logic [DistW-1:0]  d_q;
  logic [ClassW-1:0] d_cls_q;

  logic [DistW-1:0]  best_d_q [MaxK];
  logic [ClassW-1:0] best_c_q [MaxK];
  logic [KW-1:0]     filled_q;
  logic [MaxK-1:0]   le;
  logic [KW-1:0]     pos;

  logic [KW-1:0]     tally_q [NumClasses];
  logic [ClassW-1:0] win_cls_q;
  logic [KW-1:0]     win_cnt_q;

  logic              out_v_q;
  logic [ClassW-1:0] out_label_q;
  status_e           out_status_q;
  logic [DistW-1:0]  out_dist_q;

  knn_ram #(.Width(FeatBits), .Depth(MaxSamples * MaxDim)) u_feat_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.feat_we),
    .waddr_i (cmd_i.feat_waddr),
    .wdata_i (feature_i),
    .raddr_i ({cmd_i.rd_sample, cmd_i.rd_elem}),
    .rdata_o (feat_rdata)
  );

  knn_ram #(.Width(LabW), .Depth(MaxSamples)) u_lab_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.lab_we),
    .waddr_i (cmd_i.lab_waddr),
    .wdata_i ({cmd_i.lab_len, cmd_i.lab_class}),
    .raddr_i (cmd_i.rd_sample),
    .rdata_o (lab_rdata)
  );

  assign lab_len_rd = lab_rdata[LabW-1:ClassW];
  assign lab_cls_rd = lab_rdata[ClassW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.q_we) begin
      q_q[cmd_i.q_idx] <= feature_i;
    end
    if (cmd_i.qlen_we) begin
      qlen_q <= cmd_i.qlen;
    end
  end

  // elements past a vector's loaded length read as zero
  always_comb begin
    tf   = ({1'b0, p1_i_q} < lab_len_rd) ? feat_rdata : '0;
    qf   = ({1'b0, p1_i_q} < qlen_q) ? q_q[p1_i_q] : '0;
    diff = {tf[FeatBits-1], tf} - {qf[FeatBits-1], qf};
    absd = diff[FeatBits] ? (~diff + 1'b1) : diff;
  end

  always_comb begin
    acc_base = p3_first_q ? '0 : acc_q;
    acc_sum  = {1'b0, acc_base} + (DistW+1)'(p3_sq_q);
    acc_sat  = (acc_sum > {1'b0, DistCap}) ? DistCap : acc_sum[DistW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      p3_v_q <= 1'b0;
      d_v_q  <= 1'b0;
    end else begin
      p1_v_q <= cmd_i.rd_en;
      p2_v_q <= p1_v_q;
      p3_v_q <= p2_v_q;
      d_v_q  <= p3_v_q && p3_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_i_q     <= cmd_i.rd_elem;
    p1_first_q <= cmd_i.rd_first;
    p1_last_q  <= cmd_i.rd_last;
    p2_abs_q   <= absd;
    p2_first_q <= p1_first_q;
    p2_last_q  <= p1_last_q;
    p2_cls_q   <= lab_cls_rd;
    p3_sq_q    <= p2_abs_q * p2_abs_q;
    p3_first_q <= p2_first_q;
    p3_last_q  <= p2_last_q;
    p3_cls_q   <= p2_cls_q;
    if (p3_v_q) begin
      acc_q <= acc_sat;
    end
    d_q     <= acc_sat;
    d_cls_q <= p3_cls_q;
  end

  // list is sorted, so the entries not above d form a prefix
  always_comb begin
    for (int j = 0; j < MaxK; j++) begin
      le[j] = (KW'(j) < filled_q) && (best_d_q[j] <= d_q);
    end
    pos = KW'($countones(le));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q <= '0;
    end else if (cmd_i.best_clr) begin
      filled_q <= '0;
    end else if (d_v_q && (filled_q < cmd_i.kk)) begin
      filled_q <= filled_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_v_q && (pos < cmd_i.kk)) begin
      for (int j = 1; j < MaxK; j++) begin
        if (KW'(j) > pos) begin
          best_d_q[j] <= best_d_q[j-1];
          best_c_q[j] <= best_c_q[j-1];
        end
      end
      for (int j = 0; j < MaxK; j++) begin
        if (KW'(j) == pos) begin
          best_d_q[j] <= d_q;
          best_c_q[j] <= d_cls_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tally_clr) begin
      for (int c = 0; c < NumClasses; c++) begin
        tally_q[c] <= '0;
      end
    end else if (cmd_i.tally_en) begin
      tally_q[best_c_q[cmd_i.tally_idx]] <= tally_q[best_c_q[cmd_i.tally_idx]] + 1'b1;
    end
    if (cmd_i.scan_en) begin
      if (cmd_i.scan_idx == '0 || tally_q[cmd_i.scan_idx] > win_cnt_q) begin
        win_cls_q <= cmd_i.scan_idx;
        win_cnt_q <= tally_q[cmd_i.scan_idx];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_label_q  <= cmd_i.out_normal ? win_cls_q : '0;
      out_dist_q   <= cmd_i.out_normal ? best_d_q[0] : '0;
      out_status_q <= cmd_i.out_status;
    end
  end

  assign stat_o.pipe_busy = p1_v_q || p2_v_q || p3_v_q || d_v_q;
  assign stat_o.out_free  = !out_v_q || out_ready_i;
  assign out_valid_o      = out_v_q;
  assign out_label_o      = out_label_q;
  assign out_status_o     = out_status_q;
  assign out_dist_o       = out_dist_q;

endmodule
`default_nettype wire

// File: src/knn_ctrl.sv
// Controller: element loading, sample walk, tally and scan sequencing
`default_nettype none
module knn_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire knn_pkg::opcode_e            opcode_i,
  input  wire logic [knn_pkg::ClassW-1:0]  class_label_i,
  input  wire logic                        end_of_vector_i,
  input  wire logic [knn_pkg::KW-1:0]      k_eff_i,
  input  wire logic [knn_pkg::LenW-1:0]    len_eff_i,
  input  wire knn_pkg::dp_stat_t           stat_i,
  output knn_pkg::dp_cmd_t                 cmd_o
);
  import knn_pkg::*;

  ctrl_state_e        state_q, state_d;
  logic [CountW-1:0]  count_q, count_d;
  logic [DimW-1:0]    elem_q, elem_d;
  opcode_e            kind_q, kind_d;
  logic [SampleW-1:0] s_q, s_d;
  logic [DimW-1:0]    i_q, i_d;
  logic [KIdxW-1:0]   j_q, j_d;
  logic [ClassW-1:0]  c_q, c_d;
  logic [KW-1:0]      kk_q, kk_d;
  logic               few_q, few_d;

  logic [DimW-1:0] idx;
  logic [LenW-1:0] idx_inc;
  logic            last, full, i_last, s_last, accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      elem_q  <= '0;
      kind_q  <= OP_TRAIN;
      s_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      c_q     <= '0;
      kk_q    <= KW'(1);
      few_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      elem_q  <= elem_d;
      kind_q  <= kind_d;
      s_q     <= s_d;
      i_q     <= i_d;
      j_q     <= j_d;
      c_q     <= c_d;
      kk_q    <= kk_d;
      few_q   <= few_d;
    end
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    elem_d  = elem_q;
    kind_d  = kind_q;
    s_d     = s_q;
    i_d     = i_q;
    j_d     = j_q;
    c_d     = c_q;
    kk_d    = kk_q;
    few_d   = few_q;

    cmd_o            = '0;
    cmd_o.kk         = kk_q;
    cmd_o.rd_sample  = s_q;
    cmd_o.rd_elem    = i_q;
    cmd_o.tally_idx  = j_q;
    cmd_o.scan_idx   = c_q;
    cmd_o.out_status = few_q ? ST_FEW : ST_OK;
    in_ready_o       = 1'b0;

    // a load of the other kind drops a partial vector
    idx     = (elem_q != '0 && opcode_i != kind_q) ? '0 : elem_q;
    idx_inc = {1'b0, idx} + 1'b1;
    last    = end_of_vector_i || (idx_inc >= len_eff_i);
    full    = count_q >= CountW'(MaxSamples);
    i_last  = ({1'b0, i_q} + 1'b1) >= len_eff_i;
    s_last  = ({1'b0, s_q} + 1'b1) == count_q;
    accept  = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = stat_i.out_free;
        accept     = in_valid_i && stat_i.out_free;
        if (accept) begin
          case (opcode_i)
            OP_CLEAR: begin
              count_d = '0;
              elem_d  = '0;
            end
            OP_TRAIN: begin
              kind_d           = OP_TRAIN;
              cmd_o.feat_we    = !full;
              cmd_o.feat_waddr = {count_q[SampleW-1:0], idx};
              if (last) begin
                elem_d = '0;
                if (full) begin
                  cmd_o.out_load   = 1'b1;
                  cmd_o.out_status = ST_FULL;
                end else begin
                  cmd_o.lab_we    = 1'b1;
                  cmd_o.lab_waddr = count_q[SampleW-1:0];
                  cmd_o.lab_len   = idx_inc;
                  cmd_o.lab_class = class_label_i;
                  count_d         = count_q + 1'b1;
                end
              end else begin
                elem_d = idx_inc[DimW-1:0];
              end
            end
            OP_QUERY: begin
              kind_d      = OP_QUERY;
              cmd_o.q_we  = 1'b1;
              cmd_o.q_idx = idx;
              if (last) begin
                elem_d        = '0;
                cmd_o.qlen_we = 1'b1;
                cmd_o.qlen    = idx_inc;
                if (count_q == '0) begin
                  cmd_o.out_load   = 1'b1;
                  cmd_o.out_status = ST_FEW;
                end else begin
                  few_d          = CountW'(k_eff_i) > count_q;
                  kk_d           = (CountW'(k_eff_i) > count_q) ? count_q[KW-1:0] : k_eff_i;
                  cmd_o.best_clr = 1'b1;
                  s_d            = '0;
                  i_d            = '0;
                  state_d        = S_WALK;
                end
              end else begin
                elem_d = idx_inc[DimW-1:0];
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_WALK: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_first = i_q == '0;
        cmd_o.rd_last  = i_last;
        if (i_last) begin
          i_d = '0;
          if (s_last) begin
            state_d = S_DRAIN;
          end else begin
            s_d = s_q + 1'b1;
          end
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      S_DRAIN: begin
        if (!stat_i.pipe_busy) begin
          cmd_o.tally_clr = 1'b1;
          j_d             = '0;
          state_d         = S_TALLY;
        end
      end
      S_TALLY: begin
        cmd_o.tally_en = 1'b1;
        j_d            = j_q + 1'b1;
        if ((KW'(j_q) + 1'b1) >= kk_q) begin
          c_d     = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_en = 1'b1;
        c_d           = c_q + 1'b1;
        if (c_q == ClassW'(NumClasses - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_normal = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: src/knn_majority_vote_classifier_unit.sv
// Top level of the k-nearest-neighbour majority-vote classifier
// Training and query elements are taken at one item per cycle while the output
// register is free; every item waits while a result is held there unaccepted.
// The last element of a query starts a walk that reads the feature memory once
// per element of each stored sample, so the block stops taking items through
// the distance work, a tally of the min(k, count) nearest labels (count stored
// samples), a vote scan over all 16 classes and the load of the result, which
// waits for a free output register. One subtract, square and accumulate
// pipeline behind the single read port of the feature memory paces the walk.
// An empty store answers at once with status 1. Registers: index 0 is k, index 1
// the vector length; write them only while the block is idle.
`default_nettype none
module knn_majority_vote_classifier_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [0:0]                     cfg_idx_i,
  input  wire logic [knn_pkg::CfgW-1:0]       cfg_data_i,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // feature [15:0], class_label [19:16], zero [23:20]
  input  wire logic [knn_pkg::InDataW-1:0]    s_axis_tdata,
  // opcode [1:0]
  input  wire logic [1:0]                     s_axis_tuser,
  input  wire logic                           s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // predicted_label [3:0], nearest_distance [39:4]
  output logic [knn_pkg::OutDataW-1:0]        m_axis_tdata,
  // status [1:0]
  output logic [1:0]                          m_axis_tuser
);
  import knn_pkg::*;

  logic [CfgW-1:0] k_q, len_q;
  logic [KW-1:0]   k_eff;
  logic [LenW-1:0] len_eff;
  dp_cmd_t         cmd;
  dp_stat_t        stat;
  logic [ClassW-1:0] out_label;
  status_e           out_status;
  logic [DistW-1:0]  out_dist;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q   <= CfgW'(1);
      len_q <= CfgW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_NEIGHBOR_COUNT: k_q   <= cfg_data_i;
        CFG_VECTOR_LENGTH:  len_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // zero acts as one, oversize clamps to the maximum
  always_comb begin
    if (k_q == '0) begin
      k_eff = KW'(1);
    end else if (k_q > CfgW'(MaxK)) begin
      k_eff = KW'(MaxK);
    end else begin
      k_eff = k_q[KW-1:0];
    end
    if (len_q == '0) begin
      len_eff = LenW'(1);
    end else if (len_q > CfgW'(MaxDim)) begin
      len_eff = LenW'(MaxDim);
    end else begin
      len_eff = len_q[LenW-1:0];
    end
  end

  knn_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .opcode_i        (opcode_e'(s_axis_tuser)),
    .class_label_i   (s_axis_tdata[FeatBits +: ClassW]),
    .end_of_vector_i (s_axis_tlast),
    .k_eff_i         (k_eff),
    .len_eff_i       (len_eff),
    .stat_i          (stat),
    .cmd_o           (cmd)
  );

  knn_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .feature_i    (s_axis_tdata[FeatBits-1:0]),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_label_o  (out_label),
    .out_status_o (out_status),
    .out_dist_o   (out_dist)
  );

  assign m_axis_tdata = {out_dist, out_label};
  assign m_axis_tuser = out_status;

endmodule
`default_nettype wire

// File: src/knn_checker.sv
// Port-level assertions for the classifier, bound to the top level
`default_nettype none
`include "knn_majority_vote_classifier_unit_defines.svh"
module knn_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        cfg_we_i,
  input wire logic [0:0]                  cfg_idx_i,
  input wire logic [knn_pkg::CfgW-1:0]    cfg_data_i,
  input wire logic                        s_axis_tvalid,
  input wire logic                        s_axis_tready,
  input wire logic [knn_pkg::InDataW-1:0] s_axis_tdata,
  input wire logic [1:0]                  s_axis_tuser,
  input wire logic                        s_axis_tlast,
  input wire logic                        m_axis_tvalid,
  input wire logic                        m_axis_tready,
  input wire logic [knn_pkg::OutDataW-1:0] m_axis_tdata,
  input wire logic [1:0]                  m_axis_tuser
);
  import knn_pkg::*;

  logic unused;
  assign unused = cfg_we_i ^ cfg_idx_i[0] ^ (^cfg_data_i) ^ s_axis_tvalid ^
                  (^s_axis_tdata) ^ s_axis_tlast;

  `KNN_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")
  `KNN_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed while stalled")
  `KNN_ASSERT_NOW(a_full_zero, m_axis_tvalid && m_axis_tuser == ST_FULL, m_axis_tdata == '0, "store-full result not zero")
  `KNN_ASSERT_NEXT(a_query_busy, s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_QUERY && s_axis_tlast && !m_axis_tvalid, !s_axis_tready || m_axis_tvalid, "query end neither answered nor busy")

endmodule

bind knn_majority_vote_classifier_unit knn_checker u_knn_checker (.*);
`default_nettype wire
